### rtl/pts_pkg.sv
// Package for the priority task scheduler: payload structs, command codes,
// and the command and status structs between controller and datapath.
// No dependencies.
package pts_pkg;

   localparam logic [7:0]  LOCK_MAX    = 8'd255;
   localparam logic [15:0] SLICE_RESET = 16'd10;

   typedef enum logic [2:0] {
      FUNC_READY    = 3'd0,
      FUNC_UNREADY  = 3'd1,
      FUNC_DELAY    = 3'd2,
      FUNC_WAKE     = 3'd3,
      FUNC_TICK     = 3'd4,
      FUNC_LOCK     = 3'd5,
      FUNC_UNLOCK   = 3'd6,
      FUNC_SCHEDULE = 3'd7
   } func_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [4:0]  task_id;
      logic [4:0]  prio;
      logic [31:0] ticks;
      logic        waits_event;
   } req_type;

   typedef struct packed {
      logic [4:0]  next_task;
      logic        switch_now;
      logic        any_ready;
      logic [31:0] timed_out_mask;
      logic [31:0] woken_mask;
      logic [7:0]  lock_level;
      logic [31:0] tick_total;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LATCH,
      OP_EXEC,
      OP_WALK,
      OP_SLICE,
      OP_FIND_RD,
      OP_FIND_CHK,
      OP_SHIFT_RD,
      OP_SHIFT_WR,
      OP_LAST,
      OP_TICK_END,
      OP_SCHED_RD,
      OP_SCHED_CHK
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      func_type func;
      logic     task_ok;
      logic     walk_last;
      logic     rot_req;
      logic     find_end;
      logic     match;
      logic     shift_end;
      logic     lock_zero;
      logic     lock_one;
      logic     bitmap_any;
   } dp_status_type;

endpackage

### rtl/pts_datapath.sv
// Scheduler datapath: per-priority queue memory, queue pointers, bitmap,
// per-task delay/slice/priority stores and the counters.
// Depends on pts_pkg; driven by pts_ctrl through dp_cmd_type.
module pts_datapath #(
   parameter int NUM_PRIOS = 32,
   parameter int NUM_TASKS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pts_pkg::req_type      req_data,
   input  logic [15:0]           slice_max,
   input  pts_pkg::dp_cmd_type   cmd,
   output pts_pkg::dp_status_type status,
   output pts_pkg::rsp_type      result
);
   import pts_pkg::*;

   localparam int PW  = $clog2(NUM_PRIOS);
   localparam int TW  = $clog2(NUM_TASKS);
   localparam int CW  = $clog2(NUM_TASKS + 1);
   localparam int SLW = TW + 1;

   // queue storage: circular buffer per priority
   logic [TW-1:0] mem [NUM_PRIOS][NUM_TASKS];
   logic [TW-1:0] rd_ff;
   logic          mem_we;
   logic [PW-1:0] mem_wp, mem_rp;
   logic [TW-1:0] mem_ws, mem_rs, mem_wd;

   logic [CW-1:0] cnt_ff  [NUM_PRIOS];
   logic [TW-1:0] head_ff [NUM_PRIOS];
   logic          qm_we;
   logic [PW-1:0] qm_p;
   logic [CW-1:0] qm_cnt;
   logic [TW-1:0] qm_head;
   logic [NUM_PRIOS-1:0] bitmap_ff, bitmap_in;

   logic [PW-1:0] prio_ff  [NUM_TASKS];
   logic [15:0]   slice_ff [NUM_TASKS];
   logic [31:0]   delay_ff [NUM_TASKS];
   logic          prio_we, slice_we, delay_we;
   logic [TW-1:0] prio_t, slice_t, delay_t;
   logic [PW-1:0] prio_d;
   logic [15:0]   slice_d;
   logic [31:0]   delay_d;

   logic [NUM_TASKS-1:0] delayed_ff, delayed_in, evwait_ff, evwait_in;
   logic [TW-1:0] cur_ff, cur_in;
   logic [7:0]    lock_ff, lock_in;
   logic [31:0]   tickc_ff, tickc_in;
   logic [31:0]   woken_ff, woken_in, timed_ff, timed_in;
   logic          sw_ff, sw_in;

   req_type       req_ff, req_in;
   logic [TW-1:0] idx_ff, idx_in;
   logic [PW-1:0] qp_ff, qp_in;
   logic [TW-1:0] qt_ff, qt_in;
   logic [CW-1:0] pos_ff, pos_in;

   logic [TW-1:0] t_sel;
   logic [PW-1:0] p_req, low_p;
   logic          task_ok, prio_ok;
   logic [CW-1:0] pos_inc;
   logic [31:0]   dec;
   logic [15:0]   slice_dec;
   logic [PW-1:0] push_p;

   function automatic logic [TW-1:0] slot_of(input logic [TW-1:0] h,
                                             input logic [CW-1:0] i);
      logic [SLW-1:0] s;
      s = SLW'(h) + SLW'(i);
      if (s >= SLW'(NUM_TASKS)) s = s - SLW'(NUM_TASKS);
      return s[TW-1:0];
   endfunction

   function automatic logic [TW-1:0] prev_slot(input logic [TW-1:0] h);
      logic [TW-1:0] r;
      r = (h == '0) ? TW'(NUM_TASKS - 1) : h - TW'(1);
      return r;
   endfunction

   assign t_sel   = TW'(req_ff.task_id);
   assign p_req   = PW'(req_ff.prio);
   assign task_ok = 32'(req_ff.task_id) < 32'(NUM_TASKS);
   assign prio_ok = 32'(req_ff.prio) < 32'(NUM_PRIOS);
   assign pos_inc = pos_ff + CW'(1);
   assign dec     = delay_ff[idx_ff] - 32'd1;
   assign slice_dec = slice_ff[cur_ff] - 16'd1;

   always_comb begin
      low_p = '0;
      for (int k = NUM_PRIOS - 1; k >= 0; k--) begin
         if (bitmap_ff[k]) low_p = PW'(k);
      end
   end

   always_comb begin
      status.func       = func_type'(req_ff.func);
      status.task_ok    = task_ok;
      status.walk_last  = idx_ff == TW'(NUM_TASKS - 1);
      status.rot_req    = slice_ff[cur_ff] == 16'd1;
      status.find_end   = pos_ff >= cnt_ff[qp_ff];
      status.match      = rd_ff == qt_ff;
      status.shift_end  = pos_inc >= cnt_ff[qp_ff];
      status.lock_zero  = lock_ff == 8'd0;
      status.lock_one   = lock_ff == 8'd1;
      status.bitmap_any = |bitmap_ff;
   end

   always_comb begin
      result.next_task      = 5'(cur_ff);
      result.switch_now     = sw_ff;
      result.any_ready      = |bitmap_ff;
      result.timed_out_mask = timed_ff;
      result.woken_mask     = woken_ff;
      result.lock_level     = lock_ff;
      result.tick_total     = tickc_ff;
   end

   always_comb begin
      mem_we = 1'b0; mem_wp = qp_ff; mem_ws = '0; mem_wd = qt_ff;
      mem_rp = qp_ff; mem_rs = slot_of(head_ff[qp_ff], pos_ff);
      qm_we = 1'b0; qm_p = qp_ff; qm_cnt = cnt_ff[qp_ff]; qm_head = head_ff[qp_ff];
      bitmap_in = bitmap_ff;
      prio_we = 1'b0; prio_t = t_sel; prio_d = p_req;
      slice_we = 1'b0; slice_t = t_sel; slice_d = slice_max;
      delay_we = 1'b0; delay_t = t_sel; delay_d = '0;
      delayed_in = delayed_ff; evwait_in = evwait_ff;
      cur_in = cur_ff; lock_in = lock_ff; tickc_in = tickc_ff;
      woken_in = woken_ff; timed_in = timed_ff; sw_in = sw_ff;
      req_in = req_ff; idx_in = idx_ff; qp_in = qp_ff; qt_in = qt_ff; pos_in = pos_ff;
      push_p = p_req;

      case (cmd.op)
         OP_LATCH: begin
            req_in = req_data;
            woken_in = '0;
            timed_in = '0;
            sw_in = 1'b0;
         end
         OP_EXEC: begin
            case (func_type'(req_ff.func))
               FUNC_READY: begin
                  if (task_ok && prio_ok) begin
                     prio_we  = 1'b1;
                     slice_we = 1'b1;
                     if (cnt_ff[push_p] < CW'(NUM_TASKS)) begin
                        mem_we = 1'b1; mem_wp = push_p;
                        mem_ws = prev_slot(head_ff[push_p]); mem_wd = t_sel;
                        qm_we = 1'b1; qm_p = push_p;
                        qm_cnt = cnt_ff[push_p] + CW'(1);
                        qm_head = prev_slot(head_ff[push_p]);
                        bitmap_in[push_p] = 1'b1;
                     end
                  end
               end
               FUNC_UNREADY: begin
                  qp_in = prio_ff[t_sel];
                  qt_in = t_sel;
                  pos_in = '0;
               end
               FUNC_DELAY: begin
                  if (task_ok) begin
                     delay_we = 1'b1;
                     delay_d = (req_ff.ticks == 32'd0) ? 32'd1 : req_ff.ticks;
                     delayed_in[t_sel] = 1'b1;
                     evwait_in[t_sel] = req_ff.waits_event;
                  end
               end
               FUNC_WAKE: begin
                  if (task_ok) begin
                     delay_we = 1'b1;
                     delayed_in[t_sel] = 1'b0;
                     evwait_in[t_sel] = 1'b0;
                  end
               end
               FUNC_TICK:     idx_in = '0;
               FUNC_LOCK:     if (lock_ff != LOCK_MAX) lock_in = lock_ff + 8'd1;
               FUNC_UNLOCK:   if (lock_ff != 8'd0) lock_in = lock_ff - 8'd1;
               FUNC_SCHEDULE: ;
               default: ;
            endcase
         end
         OP_WALK: begin
            idx_in = idx_ff + TW'(1);
            if (delayed_ff[idx_ff]) begin
               delay_we = 1'b1; delay_t = idx_ff; delay_d = dec;
               if (dec == 32'd0) begin
                  // expired: report and put at the head of its queue
                  woken_in = woken_ff | (32'(1) << idx_ff);
                  if (evwait_ff[idx_ff]) timed_in = timed_ff | (32'(1) << idx_ff);
                  delayed_in[idx_ff] = 1'b0;
                  evwait_in[idx_ff] = 1'b0;
                  push_p = prio_ff[idx_ff];
                  if (cnt_ff[push_p] < CW'(NUM_TASKS)) begin
                     mem_we = 1'b1; mem_wp = push_p;
                     mem_ws = prev_slot(head_ff[push_p]); mem_wd = idx_ff;
                     qm_we = 1'b1; qm_p = push_p;
                     qm_cnt = cnt_ff[push_p] + CW'(1);
                     qm_head = prev_slot(head_ff[push_p]);
                     bitmap_in[push_p] = 1'b1;
                  end
               end
            end
         end
         OP_SLICE: begin
            slice_we = 1'b1; slice_t = cur_ff; slice_d = slice_dec;
            qp_in = prio_ff[cur_ff];
            qt_in = cur_ff;
            pos_in = '0;
         end
         OP_FIND_RD: ;
         OP_FIND_CHK: if (rd_ff != qt_ff) pos_in = pos_inc;
         OP_SHIFT_RD: mem_rs = slot_of(head_ff[qp_ff], pos_inc);
         OP_SHIFT_WR: begin
            mem_we = 1'b1; mem_ws = slot_of(head_ff[qp_ff], pos_ff); mem_wd = rd_ff;
            pos_in = pos_inc;
         end
         OP_LAST: begin
            if (func_type'(req_ff.func) == FUNC_TICK) begin
               // rotation: the current task goes to the tail, count unchanged
               mem_we = 1'b1;
               mem_ws = slot_of(head_ff[qp_ff], cnt_ff[qp_ff] - CW'(1));
               slice_we = 1'b1; slice_t = qt_ff;
            end else begin
               qm_we = 1'b1;
               qm_cnt = cnt_ff[qp_ff] - CW'(1);
               if (cnt_ff[qp_ff] == CW'(1)) bitmap_in[qp_ff] = 1'b0;
            end
         end
         OP_TICK_END: tickc_in = tickc_ff + 32'd1;
         OP_SCHED_RD: begin
            mem_rp = low_p;
            mem_rs = head_ff[low_p];
         end
         OP_SCHED_CHK: begin
            if (rd_ff != cur_ff) begin
               cur_in = rd_ff;
               sw_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wp][mem_ws] <= mem_wd;
      rd_ff <= mem[mem_rp][mem_rs];
   end

   always_ff @(posedge clock) begin
      if (delay_we) delay_ff[delay_t] <= delay_d;
      req_ff <= req_in;
      idx_ff <= idx_in;
      qp_ff  <= qp_in;
      qt_ff  <= qt_in;
      pos_ff <= pos_in;
      woken_ff <= woken_in;
      timed_ff <= timed_in;
      sw_ff    <= sw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_PRIOS; k++) begin
            cnt_ff[k]  <= '0;
            head_ff[k] <= '0;
         end
         for (int k = 0; k < NUM_TASKS; k++) begin
            prio_ff[k]  <= '0;
            slice_ff[k] <= '0;
         end
         bitmap_ff  <= '0;
         delayed_ff <= '0;
         evwait_ff  <= '0;
         cur_ff     <= TW'(NUM_TASKS - 1);
         lock_ff    <= '0;
         tickc_ff   <= '0;
      end else begin
         if (qm_we) begin
            cnt_ff[qm_p]  <= qm_cnt;
            head_ff[qm_p] <= qm_head;
         end
         if (prio_we) prio_ff[prio_t] <= prio_d;
         if (slice_we) slice_ff[slice_t] <= slice_d;
         bitmap_ff  <= bitmap_in;
         delayed_ff <= delayed_in;
         evwait_ff  <= evwait_in;
         cur_ff     <= cur_in;
         lock_ff    <= lock_in;
         tickc_ff   <= tickc_in;
      end
   end

endmodule

### rtl/pts_ctrl.sv
// Scheduler controller: one-hot state machine sequencing the datapath
// through command decode, delay walk, queue search/shift and scheduling.
// Depends on pts_pkg.
module pts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   rsp_free,
   output logic                   rsp_load,
   input  pts_pkg::dp_status_type status,
   output pts_pkg::dp_cmd_type    cmd
);
   import pts_pkg::*;

   typedef enum logic [12:0] {
      ST_IDLE      = 13'b0000000000001,
      ST_EXEC      = 13'b0000000000010,
      ST_WALK      = 13'b0000000000100,
      ST_SLICE     = 13'b0000000001000,
      ST_FIND_RD   = 13'b0000000010000,
      ST_FIND_CHK  = 13'b0000000100000,
      ST_SHIFT_RD  = 13'b0000001000000,
      ST_SHIFT_WR  = 13'b0000010000000,
      ST_LAST      = 13'b0000100000000,
      ST_TICK_END  = 13'b0001000000000,
      ST_SCHED_RD  = 13'b0010000000000,
      ST_SCHED_CHK = 13'b0100000000000,
      ST_RESP      = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_tick;

   assign is_tick = status.func == FUNC_TICK;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.op = OP_EXEC;
            case (status.func)
               FUNC_UNREADY:  state_in = status.task_ok ? ST_FIND_RD : ST_RESP;
               FUNC_TICK:     state_in = ST_WALK;
               FUNC_UNLOCK:   state_in = status.lock_one ? ST_SCHED_RD : ST_RESP;
               FUNC_SCHEDULE: state_in = status.lock_zero ? ST_SCHED_RD : ST_RESP;
               default:       state_in = ST_RESP;
            endcase
         end
         ST_WALK: begin
            cmd.op = OP_WALK;
            if (status.walk_last) state_in = ST_SLICE;
         end
         ST_SLICE: begin
            cmd.op   = OP_SLICE;
            state_in = status.rot_req ? ST_FIND_RD : ST_TICK_END;
         end
         ST_FIND_RD: begin
            cmd.op = OP_FIND_RD;
            if (status.find_end) state_in = is_tick ? ST_TICK_END : ST_RESP;
            else                 state_in = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            cmd.op   = OP_FIND_CHK;
            state_in = status.match ? ST_SHIFT_RD : ST_FIND_RD;
         end
         ST_SHIFT_RD: begin
            cmd.op   = OP_SHIFT_RD;
            state_in = status.shift_end ? ST_LAST : ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.op   = OP_SHIFT_WR;
            state_in = ST_SHIFT_RD;
         end
         ST_LAST: begin
            cmd.op   = OP_LAST;
            state_in = is_tick ? ST_TICK_END : ST_RESP;
         end
         ST_TICK_END: begin
            cmd.op   = OP_TICK_END;
            state_in = status.lock_zero ? ST_SCHED_RD : ST_RESP;
         end
         ST_SCHED_RD: begin
            cmd.op   = OP_SCHED_RD;
            state_in = status.bitmap_any ? ST_SCHED_CHK : ST_RESP;
         end
         ST_SCHED_CHK: begin
            cmd.op   = OP_SCHED_CHK;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### rtl/priority_task_scheduler.sv
// Channel  Ports                         Beat
// req      req_valid/req_ready/req_data  one scheduler command
// rsp      rsp_valid/rsp_ready/rsp_data  one result per command
// csr      csr_valid/csr_ready/csr_data  slice length (16 bits)
// Ready/delay/wake/lock: decode, response; unlock/schedule may also schedule;
// unready adds a queue search and shift. Tick: a delay walk over all tasks,
// a rotation search and shift when the slice ends, then scheduling if unlocked.
// Synchronous reset clears the queues, task flags, lock level and tick count at once.
// The result register lets the next command in while rsp is stalled.
module priority_task_scheduler #(
   parameter int NUM_PRIOS = 32,
   parameter int NUM_TASKS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pts_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import pts_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   rsp_type       result;
   rsp_type       rsp_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   slice_max_ff;
   logic          rsp_free, rsp_load;

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   pts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_free  (rsp_free),
      .rsp_load  (rsp_load),
      .status    (status),
      .cmd       (cmd)
   );

   pts_datapath #(
      .NUM_PRIOS (NUM_PRIOS),
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .slice_max (slice_max_ff),
      .cmd       (cmd),
      .status    (status),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (rsp_load) rsp_data_ff <= result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slice_max_ff <= SLICE_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) slice_max_ff <= csr_data;
      end
   end

endmodule
